/* hdl/png2a_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png2a_pkg
// Shared types and constants of the PNG pixel to ARGB8888 converter.
// ----------------------------------------------------------------------------
package png2a_pkg;

    // palette storage
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
    localparam int PAL_WIDTH     = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_KIND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_DEPTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_COUNT  = 2'd3;

    // color kinds that take the sub-byte path
    localparam logic [2:0] KIND_GRAY    = 3'd0;
    localparam logic [2:0] KIND_PALETTE = 3'd3;

    // sample depths
    localparam logic [4:0] DEPTH_1  = 5'd1;
    localparam logic [4:0] DEPTH_2  = 5'd2;
    localparam logic [4:0] DEPTH_4  = 5'd4;
    localparam logic [4:0] DEPTH_16 = 5'd16;

    localparam logic [4:0] DEPTH_RESET = 5'd8;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // item commands
    typedef enum logic [0:0] {
        CMD_CONVERT = 1'b0,
        CMD_LOAD    = 1'b1
    } t_cmd;

    // configuration registers
    typedef struct packed {
        logic [2:0] color_kind;
        logic [4:0] sample_depth;
        logic [8:0] palette_color_count;
        logic [8:0] palette_alpha_count;
    } t_cfg;

    // decoder result
    typedef struct packed {
        logic        is_pal;   // result comes from the palette
        logic [7:0]  pal_idx;  // palette index of the sample
        logic [31:0] argb;     // direct result for non-palette pixels
    } t_dec;

endpackage

/* hdl/png2a_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png2a_ifs
// Valid/ready channels of the converter: input word and ARGB result word.
// ----------------------------------------------------------------------------
interface png2a_pix_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [63:0] pixel_bytes;
    logic [2:0]  x_phase;
    logic [7:0]  entry_index;
    logic [23:0] entry_rgb;
    logic [7:0]  entry_alpha;

    modport source (
        output valid, command, pixel_bytes, x_phase, entry_index, entry_rgb,
               entry_alpha,
        input  ready
    );
    modport sink (
        input  valid, command, pixel_bytes, x_phase, entry_index, entry_rgb,
               entry_alpha,
        output ready
    );
endinterface

interface png2a_argb_if;
    logic        valid;
    logic        ready;
    logic [31:0] argb;

    modport source (output valid, argb, input ready);
    modport sink (input valid, argb, output ready);
endinterface

/* hdl/png2a_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png2a_decode
// Pixel decoder: sub-byte sample extraction, gray expansion, byte layouts.
// ----------------------------------------------------------------------------
module png2a_decode (
    input  png2a_pkg::t_cfg i_cfg,
    input  logic [63:0]     i_pixel_bytes,
    input  logic [2:0]      i_x_phase,
    output png2a_pkg::t_dec o_dec
);
    import png2a_pkg::*;

    logic [7:0] bytes [8];
    logic       color;
    logic       alpha;
    logic       d1, d2, d4, d16;
    logic [7:0] sample;
    logic [7:0] gray;
    logic       sub_path;

    // split the word into bytes, byte 0 highest
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            bytes[k] = i_pixel_bytes[63 - 8*k -: 8];
        end
    end

    assign color = i_cfg.color_kind[1];
    assign alpha = i_cfg.color_kind[2];

    // depth select, unsupported depths act as 8
    assign d1  = (i_cfg.sample_depth == DEPTH_1);
    assign d2  = (i_cfg.sample_depth == DEPTH_2);
    assign d4  = (i_cfg.sample_depth == DEPTH_4);
    assign d16 = (i_cfg.sample_depth == DEPTH_16);

    assign sub_path = !d16 && (i_cfg.color_kind == KIND_GRAY ||
                               i_cfg.color_kind == KIND_PALETTE);

    // sample from the first byte, msb-first slots
    always_comb begin
        priority if (d1) begin
            sample = {7'd0, bytes[0][~i_x_phase]};
            gray   = {8{bytes[0][~i_x_phase]}};
        end else if (d2) begin
            sample = {6'd0, bytes[0][{~i_x_phase[1:0], 1'b1} -: 2]};
            gray   = {4{bytes[0][{~i_x_phase[1:0], 1'b1} -: 2]}};
        end else if (d4) begin
            sample = i_x_phase[0] ? {4'd0, bytes[0][3:0]} : {4'd0, bytes[0][7:4]};
            gray   = i_x_phase[0] ? {2{bytes[0][3:0]}} : {2{bytes[0][7:4]}};
        end else begin
            sample = bytes[0];
            gray   = bytes[0];
        end
    end

    // result assembly
    always_comb begin
        o_dec.is_pal  = sub_path && (i_cfg.color_kind == KIND_PALETTE);
        o_dec.pal_idx = sample;
        if (sub_path) begin
            o_dec.argb = {ALPHA_OPAQUE, gray, gray, gray};
        end else if (d16) begin
            o_dec.argb = {alpha ? (color ? bytes[6] : bytes[2]) : ALPHA_OPAQUE,
                          bytes[0],
                          color ? bytes[2] : bytes[0],
                          color ? bytes[4] : bytes[0]};
        end else begin
            o_dec.argb = {alpha ? (color ? bytes[3] : bytes[1]) : ALPHA_OPAQUE,
                          bytes[0],
                          color ? bytes[1] : bytes[0],
                          color ? bytes[2] : bytes[0]};
        end
    end

endmodule

/* hdl/png2a_palette_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png2a_palette_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module png2a_palette_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/png_pixel_to_argb_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_pixel_to_argb_converter
// Converts one PNG pixel word to ARGB8888; load words fill the palette.
//
//   port      dir   kind         payload
//   i_pix     in    valid/ready  command, pixel_bytes, x_phase, entry_*
//   o_argb    out   valid/ready  argb
//   i_cfg_*   in    write only   color_kind, sample_depth, color/alpha counts
//
// Two stages: decode and palette read, then palette merge into the result
// register. One word per clock while the output is not stalled. Synchronous
// active-low reset clears the stage valids and the configuration registers;
// palette contents are kept. A stalled output holds the result and the
// decode stage, and i_pix.ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module png_pixel_to_argb_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [png2a_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [png2a_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    png2a_pix_if.sink                           i_pix,
    png2a_argb_if.source                        o_argb
);
    import png2a_pkg::*;

    t_cfg                 r_cfg;
    t_dec                 dec;
    logic                 accept;
    logic                 conv_acc;
    logic                 load_acc;
    logic                 pal_we;
    logic [PAL_WIDTH-1:0] pal_q;
    logic                 a_free;
    logic                 b_take;

    logic                 r_a_valid;
    logic                 r_a_is_pal;
    logic                 r_a_rgb_ok;
    logic                 r_a_alpha_ok;
    logic [31:0]          r_a_argb;
    logic                 r_b_valid;
    logic [31:0]          r_b_argb;
    logic [31:0]          n_b_argb;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.color_kind          <= KIND_GRAY;
            r_cfg.sample_depth        <= DEPTH_RESET;
            r_cfg.palette_color_count <= '0;
            r_cfg.palette_alpha_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLOR_KIND:   r_cfg.color_kind          <= i_cfg_data[2:0];
                REG_SAMPLE_DEPTH: r_cfg.sample_depth        <= i_cfg_data[4:0];
                REG_COLOR_COUNT:  r_cfg.palette_color_count <= i_cfg_data;
                REG_ALPHA_COUNT:  r_cfg.palette_alpha_count <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // handshake
    assign b_take      = !r_b_valid || o_argb.ready;
    assign a_free      = !r_a_valid || b_take;
    assign i_pix.ready = a_free;
    assign accept      = i_pix.valid && i_pix.ready;
    assign conv_acc    = accept && (i_pix.command == CMD_CONVERT);
    assign load_acc    = accept && (i_pix.command == CMD_LOAD);
    assign pal_we      = load_acc && ({1'b0, i_pix.entry_index} < 9'(PALETTE_DEPTH));

    // pixel decoder
    png2a_decode u_decode (
        .i_cfg         (r_cfg),
        .i_pixel_bytes (i_pix.pixel_bytes),
        .i_x_phase     (i_pix.x_phase),
        .o_dec         (dec)
    );

    // palette table
    png2a_palette_ram #(
        .DEPTH (PALETTE_DEPTH),
        .WIDTH (PAL_WIDTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_pix.entry_index[PAL_AW-1:0]),
        .i_wdata ({i_pix.entry_alpha, i_pix.entry_rgb}),
        .i_re    (conv_acc),
        .i_raddr (dec.pal_idx[PAL_AW-1:0]),
        .o_rdata (pal_q)
    );

    // decode stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_free) begin
            r_a_valid <= conv_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (conv_acc) begin
            r_a_is_pal   <= dec.is_pal;
            r_a_argb     <= dec.argb;
            r_a_rgb_ok   <= ({1'b0, dec.pal_idx} < 9'(PALETTE_DEPTH)) &&
                            ({1'b0, dec.pal_idx} < r_cfg.palette_color_count);
            r_a_alpha_ok <= ({1'b0, dec.pal_idx} < 9'(PALETTE_DEPTH)) &&
                            ({1'b0, dec.pal_idx} < r_cfg.palette_alpha_count);
        end
    end

    // palette merge
    always_comb begin
        if (r_a_is_pal) begin
            n_b_argb = {r_a_alpha_ok ? pal_q[31:24] : ALPHA_OPAQUE,
                        r_a_rgb_ok ? pal_q[23:0] : 24'd0};
        end else begin
            n_b_argb = r_a_argb;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_take) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_take && r_a_valid) begin
            r_b_argb <= n_b_argb;
        end
    end

    assign o_argb.valid = r_b_valid;
    assign o_argb.argb  = r_b_argb;

    // checks
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_a_valid && r_b_valid))
        else $error("input stalled with a free stage");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !b_take) |=> r_a_valid)
        else $error("decode stage word lost during output stall");

    a_no_ram_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(pal_we && conv_acc))
        else $error("palette write and read in the same cycle");

    a_opaque_beyond_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && b_take && r_a_is_pal && !r_a_alpha_ok)
            |=> (r_b_argb[31:24] == ALPHA_OPAQUE))
        else $error("palette index past alpha count not opaque");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_acc && !r_a_valid) |=> !r_a_valid)
        else $error("load word produced a result");

endmodule
